[sv/jbsr_pkg.sv]
// shared types, codes and sizes of the jitter buffer slot ring
package jbsr_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int LEVEL_W   = $clog2(NUM_SLOTS + 1);
    localparam int LEN_W     = 16;
    localparam int TAG_W     = 16;
    localparam int BYTES_W   = 16;
    localparam int OFFSET_W  = 20;
    localparam int ACT_W     = 3;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [ACT_W-1:0] ACT_CLAIM_WR = 3'd0;
    localparam logic [ACT_W-1:0] ACT_COMMIT   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CLAIM_RD = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESET    = 3'd4;

    localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FILLING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_THR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 1'b1;

    localparam logic [LEVEL_W-1:0] FILL_THR_RST   = '0;
    localparam logic [BYTES_W-1:0] SLOT_BYTES_RST = 16'd4096;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [LEN_W-1:0] write_length;
        logic [TAG_W-1:0] beat_tag;
        logic             beat_present;
    } t_cmd;

    typedef struct packed {
        logic                granted;
        logic [SLOT_W-1:0]   slot_index;
        logic [OFFSET_W-1:0] buffer_offset;
        logic [LEN_W-1:0]    stored_length;
        logic [TAG_W-1:0]    tag_out;
        logic                tag_out_valid;
        logic [LEVEL_W-1:0]  fill_level;
        logic [MODE_W-1:0]   buffer_mode;
    } t_result;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [TAG_W-1:0] tag;
        logic             tag_present;
    } t_slot_data;

    // decision of the ring controller for the beat in the input register
    typedef struct packed {
        logic               granted;
        logic [SLOT_W-1:0]  slot;
        logic               rd_grant;
        logic               commit;
        logic [SLOT_W-1:0]  wr_ptr;
        logic [SLOT_W-1:0]  rd_ptr;
        logic [LEVEL_W-1:0] level;
        logic [MODE_W-1:0]  mode;
    } t_ctrl;

endpackage

[sv/jbsr_store.sv]
// generic ram with one write port and a registered read port
module jbsr_store #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/jbsr_ctrl.sv]
// ring pointers, claim flags, fill level and mode of the slot ring
module jbsr_ctrl
    import jbsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [LEVEL_W-1:0] i_fill_thr,
    output t_ctrl              o_ctrl
);

    logic [SLOT_W-1:0]  r_wp, n_wp;
    logic [SLOT_W-1:0]  r_rp, n_rp;
    logic               r_wclaim, n_wclaim;
    logic               r_rclaim, n_rclaim;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [MODE_W-1:0]  r_mode, n_mode;

    logic [MODE_W-1:0]  start_mode;
    logic [SLOT_W-1:0]  wp_inc;
    logic [SLOT_W-1:0]  rp_inc;
    logic               full;
    logic               empty;

    // slot status follows from the ring order: the level counts ready and
    // read-claimed slots, the write slot is free unless claimed or full
    assign full  = (r_level == LEVEL_W'(NUM_SLOTS));
    assign empty = (r_level == '0);

    assign wp_inc = (r_wp == SLOT_W'(NUM_SLOTS - 1)) ? '0 : r_wp + 1'b1;
    assign rp_inc = (r_rp == SLOT_W'(NUM_SLOTS - 1)) ? '0 : r_rp + 1'b1;

    assign start_mode = (r_mode != MODE_STOPPED) ? r_mode
                      : ((i_fill_thr == '0) ? MODE_RUNNING : MODE_FILLING);

    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_wclaim = r_wclaim;
        n_rclaim = r_rclaim;
        n_level  = r_level;
        n_mode   = r_mode;
        o_ctrl.granted  = 1'b0;
        o_ctrl.slot     = '0;
        o_ctrl.rd_grant = 1'b0;
        o_ctrl.commit   = 1'b0;
        if (i_vld) begin
            unique case (i_action)
                ACT_CLAIM_WR: begin
                    n_mode      = start_mode;
                    o_ctrl.slot = r_wp;
                    if (!r_wclaim && !full) begin
                        n_wclaim       = 1'b1;
                        o_ctrl.granted = 1'b1;
                    end
                end
                ACT_COMMIT: begin
                    o_ctrl.slot = r_wp;
                    if (r_wclaim) begin
                        n_wclaim       = 1'b0;
                        n_wp           = wp_inc;
                        n_level        = full ? r_level : r_level + 1'b1;
                        o_ctrl.commit  = 1'b1;
                        o_ctrl.granted = 1'b1;
                        if (r_mode == MODE_FILLING && n_level >= i_fill_thr) begin
                            n_mode = MODE_RUNNING;
                        end
                    end
                end
                ACT_CLAIM_RD: begin
                    n_mode      = start_mode;
                    o_ctrl.slot = r_rp;
                    if (start_mode == MODE_RUNNING && !empty && !r_rclaim) begin
                        n_rclaim        = 1'b1;
                        o_ctrl.rd_grant = 1'b1;
                        o_ctrl.granted  = 1'b1;
                    end
                end
                ACT_RELEASE: begin
                    o_ctrl.slot = r_rp;
                    if (r_rclaim) begin
                        n_rclaim       = 1'b0;
                        n_rp           = rp_inc;
                        n_level        = empty ? r_level : r_level - 1'b1;
                        o_ctrl.granted = 1'b1;
                        if (r_mode == MODE_RUNNING && n_level == '0 && i_fill_thr != '0) begin
                            n_mode = MODE_FILLING;
                        end
                    end
                end
                ACT_RESET: begin
                    n_wp     = '0;
                    n_rp     = '0;
                    n_wclaim = 1'b0;
                    n_rclaim = 1'b0;
                    n_level  = '0;
                    n_mode   = MODE_STOPPED;
                    o_ctrl.granted = 1'b1;
                end
                default: begin
                end
            endcase
        end
        o_ctrl.wr_ptr = r_wp;
        o_ctrl.rd_ptr = r_rp;
        o_ctrl.level  = n_level;
        o_ctrl.mode   = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_wclaim <= 1'b0;
            r_rclaim <= 1'b0;
            r_level  <= '0;
            r_mode   <= MODE_STOPPED;
        end else begin
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_wclaim <= n_wclaim;
            r_rclaim <= n_rclaim;
            r_level  <= n_level;
            r_mode   <= n_mode;
        end
    end

endmodule

[sv/jitter_buffer_slot_ring.sv]
// jitter buffer slot ring: descriptor controller for a ring of buffer slots
//
// commands enter on i_cmd with i_start; o_busy is always low, so a command
// is taken at every edge where i_start is high. each command gives exactly
// one beat on o_result, marked by o_strobe for one cycle: the command passes
// the input register and then the result register, and the beat is taken at
// the edge that closes its strobe cycle. commands stream at one per cycle:
// the input register feeds one pass of ring control and a 4x16 offset
// multiply into the result register, and the ring state is updated at the
// same edge, so the next command sees it. the slot store is read at the
// read pointer on that same edge and its read register supplies the stored
// length and tag of a granted read claim.
// claims that cannot proceed are refused with granted low, never queued.
// configuration: i_cfg_we writes fill_threshold (index 0) or slot_bytes
// (index 1) from i_cfg_data; write only while no command is in flight.
// reset (i_rst_n low, synchronous) frees all slots, clears pointers, level
// and mode, and sets fill_threshold to 0 and slot_bytes to 4096; stored
// lengths and tags are not cleared.
// the receiver cannot stall: every strobed beat is taken in its cycle.
module jitter_buffer_slot_ring
    import jbsr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_cmd                 i_cmd,
    output logic                 o_strobe,
    output t_result              o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic               r_cmd_vld;
    t_cmd               r_cmd;
    logic               r_res_vld;
    t_result            r_res, n_res;
    logic               r_rd_grant;
    logic [LEVEL_W-1:0] r_fill_thr;
    logic [BYTES_W-1:0] r_slot_bytes;

    t_ctrl              ctrl;
    t_slot_data         wr_data;
    t_slot_data         rd_data;
    logic               accept;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_thr   <= FILL_THR_RST;
            r_slot_bytes <= SLOT_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILL_THR:   r_fill_thr   <= i_cfg_data[LEVEL_W-1:0];
                CFG_SLOT_BYTES: r_slot_bytes <= i_cfg_data[BYTES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
        end else begin
            r_cmd_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
    end

    jbsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_cmd_vld),
        .i_action   (r_cmd.action),
        .i_fill_thr (r_fill_thr),
        .o_ctrl     (ctrl)
    );

    assign wr_data.length      = r_cmd.write_length;
    assign wr_data.tag         = r_cmd.beat_tag;
    assign wr_data.tag_present = r_cmd.beat_present;

    // read port follows the read pointer, so its register holds the read slot
    jbsr_store #(
        .WIDTH ($bits(t_slot_data)),
        .DEPTH (NUM_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ctrl.commit),
        .i_waddr (ctrl.wr_ptr),
        .i_wdata (wr_data),
        .i_raddr (ctrl.rd_ptr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_res.granted       = ctrl.granted;
        n_res.slot_index    = ctrl.slot;
        n_res.buffer_offset = OFFSET_W'(ctrl.slot) * OFFSET_W'(r_slot_bytes);
        n_res.stored_length = '0;
        n_res.tag_out       = '0;
        n_res.tag_out_valid = 1'b0;
        n_res.fill_level    = ctrl.level;
        n_res.buffer_mode   = ctrl.mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= r_cmd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmd_vld) begin
            r_res      <= n_res;
            r_rd_grant <= ctrl.rd_grant;
        end
    end

    assign o_strobe = r_res_vld;

    always_comb begin
        o_result = r_res;
        if (r_rd_grant) begin
            o_result.stored_length = rd_data.length;
            o_result.tag_out       = rd_data.tag;
            o_result.tag_out_valid = rd_data.tag_present;
        end
    end

    // every accepted command yields its beat via the input and result registers
    a_beat_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_strobe)
        else $error("command without result beat");

    // a delivered tag only comes with a granted read while running
    a_tag_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.tag_out_valid |->
            o_result.granted && o_result.buffer_mode == MODE_RUNNING)
        else $error("tag delivered outside a granted read claim");

    // the level never exceeds the ring size
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.fill_level <= LEVEL_W'(NUM_SLOTS))
        else $error("fill level beyond ring size");

endmodule
